@@ hdl/weekly_alarm_scheduler_macros.svh @@
// assertion macros for the weekly alarm scheduler
`ifndef WEEKLY_ALARM_SCHEDULER_MACROS_SVH
`define WEEKLY_ALARM_SCHEDULER_MACROS_SVH

// antecedent implies consequent in the same cycle, on clk, quiet in rst
`define WAS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold, on clk, quiet in rst
`define WAS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

@@ hdl/was_pkg.sv @@
// types, constants and codes of the weekly alarm scheduler
package was_pkg;

  localparam int TIME_W       = 40;
  localparam int STIME_W      = TIME_W + 2;
  localparam int OFFSET_W     = 20;
  localparam int CFG_W        = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int NEXT_INDEX_W = 6;

  localparam int TABLE_DEPTH_DEFAULT = 64;

  localparam int WEEK_SECONDS = 604800;
  localparam int WEEK_START   = 345600;
  localparam int WEEK_BIAS    = WEEK_SECONDS - WEEK_START;

  localparam int WARN_RESET = 300;
  localparam int ON_RESET   = 20;

  // remainder unit: digits of MOD_DIGIT bits per cycle over the biased time
  localparam int MOD_SUM_W = TIME_W + 1;
  localparam int MOD_DIGIT = 4;
  localparam int MOD_STEPS = (MOD_SUM_W + MOD_DIGIT - 1) / MOD_DIGIT;
  localparam int MOD_X_W   = MOD_STEPS * MOD_DIGIT;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_ARM    = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_WARN = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ON   = 1'd1;

  typedef struct packed {
    logic [1:0]          command;
    logic [OFFSET_W-1:0] entry_offset;
    logic [TIME_W-1:0]   now;
    logic                suppress_refresh;
  } was_in_t;

  typedef struct packed {
    logic                    show_alarm;
    logic                    beep;
    logic                    refresh_request;
    logic                    rolled_over;
    logic [NEXT_INDEX_W-1:0] next_index;
    logic [TIME_W-1:0]       next_time;
    logic                    is_armed;
    logic [1:0]              status;
  } was_out_t;

endpackage

@@ hdl/was_week_mod.sv @@
// week offset unit: (t + week bias) mod week length, one digit of MOD_DIGIT bits per cycle
module was_week_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [was_pkg::TIME_W-1:0]    t,
  output logic                          done,
  output logic [was_pkg::OFFSET_W-1:0]  rem
);
  import was_pkg::*;

  logic                 busy;
  logic [MOD_CNT_W-1:0] cnt;
  logic [MOD_X_W-1:0]   x;
  logic [OFFSET_W-1:0]  r;
  logic [OFFSET_W-1:0]  r_next;
  logic [OFFSET_W:0]    acc;
  logic [MOD_SUM_W-1:0] biased;

  assign biased = MOD_SUM_W'(t) + MOD_SUM_W'(WEEK_BIAS);

  // one restoring step per bit; remainder stays below the week length
  always_comb begin
    acc = {1'b0, r};
    for (int k = 0; k < MOD_DIGIT; k++) begin
      acc = {acc[OFFSET_W-1:0], x[MOD_X_W-1-k]};
      if (acc >= (OFFSET_W+1)'(WEEK_SECONDS)) begin
        acc = acc - (OFFSET_W+1)'(WEEK_SECONDS);
      end
    end
    r_next = acc[OFFSET_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= MOD_X_W'(biased);
      r <= '0;
    end else if (busy) begin
      x <= x << MOD_DIGIT;
      r <= r_next;
    end
  end

  assign rem = r;

endmodule

@@ hdl/weekly_alarm_scheduler.sv @@
// weekly alarm scheduler top level: offset table, alarm search and tick logic
//
//   channel  dir  handshake                   payload
//   item     in   item_valid / item_stall     was_in_t  (command, offset, now, suppress)
//   result   out  result_valid / result_stall was_out_t (window, beep, next alarm, status)
//   cfg      in   cfg_write                   cfg_index, cfg_data (warn, on seconds)
//
// clear, append and an unarmed tick go from S_EXEC to S_DONE, a tick without rollover
// through S_TWIN, S_TCMP and S_SHOW; arm and a rolling tick also run the week offset
// unit over its 11 digit steps, then the table reads one entry a cycle
// reset is synchronous; the table itself is not cleared, only its fill count
// one word is in work at a time; a finished result waits in the output
// register, so the next word is taken while the result side stalls
`include "weekly_alarm_scheduler_macros.svh"

module weekly_alarm_scheduler #(
  parameter int TABLE_DEPTH = was_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  was_pkg::was_in_t                item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output was_pkg::was_out_t               result,
  input  logic                            cfg_write,
  input  logic [was_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [was_pkg::CFG_W-1:0]       cfg_data
);
  import was_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_TWIN  = 4'd2;
  localparam logic [3:0] S_TCMP  = 4'd3;
  localparam logic [3:0] S_MOD   = 4'd4;
  localparam logic [3:0] S_BASE  = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_PLACE = 4'd7;
  localparam logic [3:0] S_SHOW  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  was_in_t    item_q;

  // configuration
  logic [CFG_W-1:0] warn_seconds;
  logic [CFG_W-1:0] on_seconds;

  // scheduler state
  logic [CW-1:0]     entry_count;
  logic [TIME_W-1:0] alarm_abs_time;
  logic [IW-1:0]     alarm_slot;
  logic              armed_flag;
  logic              beeped_flag;
  logic [TIME_W-1:0] last_redraw;

  // word result being built
  logic       res_show;
  logic       res_beep;
  logic       res_refresh;
  logic       res_rolled;
  logic [1:0] res_status;
  logic       res_load;

  // alarm window ends, wide enough for no wrap
  logic signed [STIME_W-1:0] ontime;
  logic signed [STIME_W-1:0] offtime;
  logic signed [STIME_W-1:0] now_s;
  logic signed [STIME_W-1:0] last_s;
  logic                      past_off;
  logic                      refresh_hit;

  // alarm search
  logic                      mod_start;
  logic                      mod_done;
  logic [OFFSET_W-1:0]       mod_rem;
  logic [OFFSET_W-1:0]       woff;
  logic signed [STIME_W-1:0] wstart;
  logic signed [STIME_W-1:0] wnext;
  logic [CW-1:0]             rd_ptr;
  logic                      rd_vld;
  logic [IW-1:0]             rd_idx;
  logic                      scan_first;
  logic                      found;
  logic [OFFSET_W-1:0]       best_val;
  logic [IW-1:0]             best_idx;
  logic [OFFSET_W-1:0]       low_val;
  logic [IW-1:0]             low_idx;
  logic signed [STIME_W-1:0] place_base;
  logic [OFFSET_W-1:0]       place_off;
  logic signed [STIME_W-1:0] place_at;
  logic [TIME_W-1:0]         place_time;

  // offset table
  logic [OFFSET_W-1:0] offset_table [TABLE_DEPTH];
  logic                tbl_we;
  logic [IW-1:0]       tbl_waddr;
  logic                tbl_re;
  logic [IW-1:0]       tbl_raddr;
  logic [OFFSET_W-1:0] tbl_rdata;

  logic                      table_full;
  logic [IW+NEXT_INDEX_W-1:0] slot_wide;

  assign item_stall = (state != S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      warn_seconds <= CFG_W'(WARN_RESET);
      on_seconds   <= CFG_W'(ON_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WARN: warn_seconds <= cfg_data;
        CFG_ON:   on_seconds   <= cfg_data;
        default:  ;
      endcase
    end
  end

  // table memory, one write and one registered read port
  assign table_full = (entry_count >= CW'(TABLE_DEPTH));
  assign tbl_we     = (state == S_EXEC) && (item_q.command == CMD_APPEND) && !table_full;
  assign tbl_waddr  = entry_count[IW-1:0];
  assign tbl_re     = (state == S_SCAN) && (rd_ptr < entry_count);
  assign tbl_raddr  = rd_ptr[IW-1:0];

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      offset_table[tbl_waddr] <= item_q.entry_offset;
    end
    if (tbl_re) begin
      tbl_rdata <= offset_table[tbl_raddr];
    end
  end

  // week offset starts on arm, or on a tick whose window has closed, if the table is not empty
  assign mod_start = (entry_count != '0) &&
                     ((state == S_EXEC && item_q.command == CMD_ARM) ||
                      (state == S_TCMP && past_off));

  was_week_mod u_week_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .t     (item_q.now),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // window compares on the stored ends
  assign now_s    = $signed(STIME_W'(item_q.now));
  assign last_s   = $signed(STIME_W'(last_redraw));
  assign past_off = (now_s >= offtime);
  assign refresh_hit = !item_q.suppress_refresh &&
                       ((now_s >= ontime && now_s <= offtime && last_s < ontime) ||
                        (past_off && last_s > ontime && last_s < offtime));

  // alarm placement: this week if some entry lies ahead, else next week
  assign place_base = found ? wstart : wnext;
  assign place_off  = found ? best_val : low_val;
  assign place_at   = place_base + $signed(STIME_W'(place_off));

  always_comb begin
    if (place_at[STIME_W-1]) begin
      place_time = '0;
    end else if (place_at[STIME_W-2:TIME_W] != '0) begin
      place_time = '1;
    end else begin
      place_time = place_at[TIME_W-1:0];
    end
  end

  // word leaves for the output register once that register is free
  assign res_load = (state == S_DONE) && (!result_valid || !result_stall);

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      entry_count    <= '0;
      alarm_abs_time <= '0;
      alarm_slot     <= '0;
      armed_flag     <= 1'b0;
      beeped_flag    <= 1'b0;
      last_redraw    <= '0;
      rd_vld         <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            item_q      <= item;
            res_show    <= 1'b0;
            res_beep    <= 1'b0;
            res_refresh <= 1'b0;
            res_rolled  <= 1'b0;
            res_status  <= STATUS_OK;
            state       <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (item_q.command)
            CMD_CLEAR: begin
              entry_count <= '0;
              armed_flag  <= 1'b0;
              state       <= S_DONE;
            end
            CMD_APPEND: begin
              if (table_full) begin
                res_status <= STATUS_FULL;
              end else begin
                entry_count <= entry_count + 1'b1;
              end
              state <= S_DONE;
            end
            CMD_ARM: begin
              if (entry_count == '0) begin
                res_status <= STATUS_EMPTY;
                state      <= S_DONE;
              end else begin
                state <= S_MOD;
              end
            end
            default: begin
              // tick; an unarmed scheduler reports nothing
              state <= armed_flag ? S_TWIN : S_DONE;
            end
          endcase
        end
        S_TWIN: begin
          ontime  <= $signed(STIME_W'(alarm_abs_time)) - $signed(STIME_W'(warn_seconds));
          offtime <= $signed(STIME_W'(alarm_abs_time)) + $signed(STIME_W'(on_seconds));
          state   <= res_rolled ? S_SHOW : S_TCMP;
        end
        S_TCMP: begin
          // redraw request is judged on the alarm before any rollover
          res_refresh <= refresh_hit;
          if (past_off && entry_count != '0) begin
            state <= S_MOD;
          end else begin
            state <= S_SHOW;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            woff  <= mod_rem;
            state <= S_BASE;
          end
        end
        S_BASE: begin
          wstart     <= $signed(STIME_W'(item_q.now)) - $signed(STIME_W'(woff));
          rd_ptr     <= '0;
          rd_vld     <= 1'b0;
          scan_first <= 1'b1;
          found      <= 1'b0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          wnext <= wstart + $signed(STIME_W'(WEEK_SECONDS));
          if (tbl_re) begin
            rd_ptr <= rd_ptr + 1'b1;
            rd_idx <= rd_ptr[IW-1:0];
          end
          rd_vld <= tbl_re;
          if (rd_vld) begin
            // strict compares keep the lowest index on ties
            scan_first <= 1'b0;
            if (scan_first || tbl_rdata < low_val) begin
              low_val <= tbl_rdata;
              low_idx <= rd_idx;
            end
            if (tbl_rdata > woff && (!found || tbl_rdata < best_val)) begin
              best_val <= tbl_rdata;
              best_idx <= rd_idx;
              found    <= 1'b1;
            end
          end
          if (!tbl_re && !rd_vld) begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          alarm_abs_time <= place_time;
          alarm_slot     <= found ? best_idx : low_idx;
          last_redraw    <= item_q.now;
          beeped_flag    <= 1'b0;
          res_rolled     <= 1'b1;
          if (item_q.command == CMD_ARM) begin
            armed_flag <= 1'b1;
            state      <= S_DONE;
          end else begin
            state <= S_TWIN;
          end
        end
        S_SHOW: begin
          if (now_s >= ontime && now_s < offtime) begin
            res_show <= 1'b1;
            if (!beeped_flag) begin
              res_beep    <= 1'b1;
              beeped_flag <= 1'b1;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // hand the word over once the output register is free
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output valid: set on a new word, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  assign slot_wide = (IW + NEXT_INDEX_W)'(alarm_slot);

  // output register payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      result.show_alarm      <= res_show;
      result.beep            <= res_beep;
      result.refresh_request <= res_refresh;
      result.rolled_over     <= res_rolled;
      result.next_index      <= slot_wide[NEXT_INDEX_W-1:0];
      result.next_time       <= alarm_abs_time;
      result.is_armed        <= armed_flag;
      result.status          <= res_status;
    end
  end

  `WAS_ASSERT_NEVER(a_count_range, entry_count > CW'(TABLE_DEPTH), "fill count above depth")
  `WAS_ASSERT_IMPLIES(a_armed_nonempty, armed_flag, entry_count != '0, "armed with empty table")
  `WAS_ASSERT_IMPLIES(a_slot_in_table, armed_flag, alarm_slot < entry_count, "slot beyond table")
  `WAS_ASSERT_IMPLIES(a_beep_shows, result_valid && result.beep, result.show_alarm, "beep off window")
  `WAS_ASSERT_IMPLIES(a_mod_expected, mod_done, state == S_MOD, "week offset done out of turn")

endmodule

@@ bench/tb_weekly_alarm_scheduler.sv @@
// self-checking testbench for the weekly alarm scheduler: directed table, then random bursts
module tb_weekly_alarm_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import was_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEFAULT;
  localparam longint TIME_MAX = (64'd1 << TIME_W) - 1;
  localparam int PHASE_WORDS = 170;
  localparam int PHASES = 5;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SCRIPT_ROWS = 21;

  // one row of the directed script; result is typed in only where typed is set
  typedef struct {
    was_in_t  word;
    bit       typed;
    was_out_t result;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  was_in_t                item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  was_out_t               result;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_WARN;
  logic [CFG_W-1:0]       cfg_data = '0;

  // scheduler state as the bench sees it
  logic [OFFSET_W-1:0]     sched_offsets [DEPTH];
  int unsigned             sched_count;
  logic [TIME_W-1:0]       sched_alarm;
  logic [NEXT_INDEX_W-1:0] sched_slot;
  bit                      sched_armed;
  bit                      sched_beeped;
  logic [TIME_W-1:0]       sched_redraw;
  longint                  warn_s;
  longint                  on_s;

  // results still owed by the block, oldest first
  was_out_t pending_results [$];

  script_row_t script [SCRIPT_ROWS];

  bit calm = 1'b0;
  int cycles = 0;
  int mismatches = 0;
  int words_sent = 0;
  int results_checked = 0;
  int beeps_seen = 0;
  int rollovers_seen = 0;
  int drops_seen = 0;

  weekly_alarm_scheduler u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_weekly_alarm_scheduler: done, errors");
      $finish;
    end
  end

  // result side backpressure, random at about 11 percent unless calm
  always @(negedge clk) begin
    result_stall <= !rst && !calm && ($urandom_range(99) < 11);
  end

  // pick the next alarm for absolute time t: smallest entry past the week offset,
  // else the smallest entry one week on; lowest index wins ties
  function automatic void pick_alarm(logic [TIME_W-1:0] t);
    longint woff;
    longint wstart;
    longint at;
    int     best;
    int     lowest;
    bit     found;
    woff = (longint'(t) + WEEK_BIAS) % WEEK_SECONDS;
    wstart = longint'(t) - woff;
    best = 0;
    lowest = 0;
    found = 1'b0;
    for (int i = 0; i < int'(sched_count); i++) begin
      if (sched_offsets[i] < sched_offsets[lowest]) lowest = i;
      if (longint'(sched_offsets[i]) > woff &&
          (!found || sched_offsets[i] < sched_offsets[best])) begin
        best = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      best = lowest;
      wstart += WEEK_SECONDS;
    end
    at = wstart + longint'(sched_offsets[best]);
    // alarm past the 40-bit time range saturates
    if (at < 0) at = 0;
    if (at > TIME_MAX) at = TIME_MAX;
    sched_alarm = at[TIME_W-1:0];
    sched_slot = best[NEXT_INDEX_W-1:0];
    sched_redraw = t;
    sched_beeped = 1'b0;
  endfunction

  // advance the scheduler state by one accepted word and return its result
  function automatic was_out_t predict_word(was_in_t w);
    was_out_t r;
    longint   n;
    longint   last;
    longint   ontime;
    longint   offtime;
    r = '0;
    case (w.command)
      CMD_CLEAR: begin
        // table contents stay, only the fill count and arming go
        sched_count = 0;
        sched_armed = 1'b0;
      end
      CMD_APPEND: begin
        if (sched_count < DEPTH) begin
          sched_offsets[sched_count] = w.entry_offset;
          sched_count++;
        end else begin
          r.status = STATUS_FULL;
        end
      end
      CMD_ARM: begin
        if (sched_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          pick_alarm(w.now);
          sched_armed = 1'b1;
          r.rolled_over = 1'b1;
        end
      end
      CMD_TICK: begin
        if (sched_armed) begin
          // window ends in wide signed arithmetic, ontime may go negative
          n = longint'(w.now);
          last = longint'(sched_redraw);
          ontime = longint'(sched_alarm) - warn_s;
          offtime = longint'(sched_alarm) + on_s;
          // redraw request comes from the alarm before any rollover
          if (!w.suppress_refresh) begin
            if (n >= ontime && n <= offtime && last < ontime)
              r.refresh_request = 1'b1;
            else if (n >= offtime && last > ontime && last < offtime)
              r.refresh_request = 1'b1;
          end
          if (n >= offtime && sched_count != 0) begin
            pick_alarm(w.now);
            r.rolled_over = 1'b1;
            ontime = longint'(sched_alarm) - warn_s;
            offtime = longint'(sched_alarm) + on_s;
          end
          if (n >= ontime && n < offtime) begin
            r.show_alarm = 1'b1;
            if (!sched_beeped) begin
              r.beep = 1'b1;
              sched_beeped = 1'b1;
            end
          end
        end
      end
    endcase
    r.next_index = sched_slot;
    r.next_time = sched_alarm;
    r.is_armed = sched_armed;
    return r;
  endfunction

  function automatic was_in_t make_word(logic [1:0] cmd, logic [OFFSET_W-1:0] off,
                                        logic [TIME_W-1:0] t, logic sup);
    was_in_t w;
    w.command = cmd;
    w.entry_offset = off;
    w.now = t;
    w.suppress_refresh = sup;
    return w;
  endfunction

  function automatic script_row_t row(logic [1:0] cmd, logic [OFFSET_W-1:0] off,
                                      logic [TIME_W-1:0] t, logic sup, bit typed,
                                      logic [1:0] st);
    script_row_t s;
    s.word = make_word(cmd, off, t, sup);
    s.typed = typed;
    s.result = '0;
    s.result.status = st;
    return s;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [7:0] hi;
    hi = 8'($urandom_range(255));
    return {hi, $urandom};
  endfunction

  // offsets that lean on the week start, the week end and tiny values
  function automatic logic [OFFSET_W-1:0] rand_offset();
    case ($urandom_range(4))
      0: return OFFSET_W'($urandom_range(3));
      1: return OFFSET_W'(WEEK_BIAS + $urandom_range(70000));
      2: return OFFSET_W'(WEEK_SECONDS - 1 - $urandom_range(3));
      default: return OFFSET_W'($urandom_range(WEEK_SECONDS - 1));
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // compare each accepted result word with the oldest one owed
  always @(posedge clk) begin : watch_results
    was_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("show_alarm", want.show_alarm, result.show_alarm);
        check_field("beep", want.beep, result.beep);
        check_field("refresh_request", want.refresh_request, result.refresh_request);
        check_field("rolled_over", want.rolled_over, result.rolled_over);
        check_field("next_index", want.next_index, result.next_index);
        check_field("next_time", want.next_time, result.next_time);
        check_field("is_armed", want.is_armed, result.is_armed);
        check_field("status", want.status, result.status);
        results_checked++;
      end
    end
  end

  // drive one word at a falling edge, hold it until taken, then book its result
  task automatic send_word(was_in_t w, bit typed = 1'b0, was_out_t fixed = '0);
    was_out_t r;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 11) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    r = predict_word(w);
    beeps_seen += r.beep;
    rollovers_seen += r.rolled_over;
    drops_seen += (r.status == STATUS_FULL);
    pending_results.push_back(typed ? fixed : r);
    words_sent++;
  endtask

  // drop valid and wait until the block owes nothing
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write both window registers, one per cycle, block idle
  task automatic program_window(logic [CFG_W-1:0] warn, logic [CFG_W-1:0] on_val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_WARN;
    cfg_data <= warn;
    @(negedge clk);
    cfg_index <= CFG_ON;
    cfg_data <= on_val;
    @(negedge clk);
    cfg_write <= 1'b0;
    warn_s = warn;
    on_s = on_val;
  endtask

  // well-formed schedule: clear, fill, arm, then ticks that home in on the window edges
  task automatic run_schedule(bit overfill);
    int                  n_entries;
    int                  n_ticks;
    int                  pick;
    logic [TIME_W-1:0]   clock_s;
    logic [OFFSET_W-1:0] off;
    longint              target;
    send_word(make_word(CMD_CLEAR, rand_offset(), rand_time(), 1'($urandom_range(1))));
    if (overfill || $urandom_range(9) == 0) n_entries = $urandom_range(60, DEPTH + 6);
    else n_entries = $urandom_range(1, 6);
    off = rand_offset();
    for (int i = 0; i < n_entries; i++) begin
      // repeat an offset now and then so ties get exercised
      if ($urandom_range(4) != 0) off = rand_offset();
      send_word(make_word(CMD_APPEND, off, rand_time(), 1'($urandom_range(1))));
    end
    clock_s = ($urandom_range(3) == 0) ? TIME_W'($urandom_range(2000)) : rand_time();
    send_word(make_word(CMD_ARM, rand_offset(), clock_s, 1'($urandom_range(1))));
    n_ticks = $urandom_range(8, 30);
    for (int i = 0; i < n_ticks; i++) begin
      pick = $urandom_range(99);
      if (pick < 35)
        target = longint'(clock_s) + longint'($urandom_range(1, 40));
      else if (pick < 65)
        target = longint'(sched_alarm) - warn_s + longint'($urandom_range(4)) - 2;
      else if (pick < 90)
        target = longint'(sched_alarm) + on_s + longint'($urandom_range(4)) - 2;
      else
        target = longint'(rand_time());
      if (target < 0) target = 0;
      if (target > TIME_MAX) target = TIME_MAX;
      clock_s = target[TIME_W-1:0];
      send_word(make_word(CMD_TICK, rand_offset(), clock_s, $urandom_range(6) == 0));
    end
  endtask

  // a few words of anything
  task automatic run_noise();
    int n_words;
    n_words = $urandom_range(1, 4);
    for (int i = 0; i < n_words; i++) begin
      send_word(make_word(2'($urandom_range(3)), OFFSET_W'($urandom_range(WEEK_SECONDS - 1)),
                          rand_time(), 1'($urandom_range(1))));
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] warn_pick;
    logic [CFG_W-1:0] on_pick;
    int               goal;

    // bench copy of the reset state
    for (int i = 0; i < DEPTH; i++) sched_offsets[i] = '0;
    sched_count = 0;
    sched_alarm = '0;
    sched_slot = '0;
    sched_armed = 1'b0;
    sched_beeped = 1'b0;
    sched_redraw = '0;
    warn_s = WARN_RESET;
    on_s = ON_RESET;

    // directed script at the reset window of 300 / 20
    script = '{
      // tick while disarmed: all quiet
      row(CMD_TICK,   '0,           40'd12345,        1'b0, 1'b1, STATUS_OK),
      // arm with nothing in the table
      row(CMD_ARM,    '0,           '0,               1'b0, 1'b1, STATUS_EMPTY),
      // fill: zero, an offset past one week, the last second of the week, a tie
      row(CMD_APPEND, '0,           '0,               1'b0, 1'b1, STATUS_OK),
      row(CMD_APPEND, '1,           '1,               1'b1, 1'b1, STATUS_OK),
      row(CMD_APPEND, 20'd604799,   '0,               1'b0, 1'b1, STATUS_OK),
      row(CMD_APPEND, 20'd100000,   '0,               1'b0, 1'b1, STATUS_OK),
      row(CMD_APPEND, 20'd100000,   '0,               1'b0, 1'b1, STATUS_OK),
      // arm at time zero, alarm lands at 345599
      row(CMD_ARM,    '0,           '0,               1'b0, 1'b0, STATUS_OK),
      // just before the window, first second, second second, off edge
      row(CMD_TICK,   '0,           40'd345298,       1'b0, 1'b0, STATUS_OK),
      row(CMD_TICK,   '0,           40'd345299,       1'b0, 1'b0, STATUS_OK),
      row(CMD_TICK,   '0,           40'd345300,       1'b0, 1'b0, STATUS_OK),
      row(CMD_TICK,   '0,           40'd345619,       1'b0, 1'b0, STATUS_OK),
      // open the tied alarm's window with redraw suppressed
      row(CMD_TICK,   '0,           40'd445300,       1'b1, 1'b0, STATUS_OK),
      // last representable second: the next alarm saturates
      row(CMD_TICK,   '0,           '1,               1'b0, 1'b0, STATUS_OK),
      row(CMD_TICK,   '0,           '0,               1'b0, 1'b0, STATUS_OK),
      row(CMD_CLEAR,  '1,           '1,               1'b1, 1'b0, STATUS_OK),
      row(CMD_TICK,   '0,           '1,               1'b0, 1'b0, STATUS_OK),
      row(CMD_ARM,    '0,           '0,               1'b0, 1'b0, STATUS_OK),
      row(CMD_APPEND, 20'd1,        '0,               1'b0, 1'b0, STATUS_OK),
      row(CMD_ARM,    '0,           '1,               1'b0, 1'b0, STATUS_OK),
      row(CMD_TICK,   '0,           40'hFF_FFFF_FFFE, 1'b1, 1'b0, STATUS_OK)
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_word(script[i].word, script[i].typed, script[i].result);

    // random phases, each under its own window setting; the middle one runs calm
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin
          warn_pick = '0;
          on_pick = '0;
        end
        1: begin
          warn_pick = '1;
          on_pick = '1;
        end
        3: begin
          warn_pick = CFG_W'(WARN_RESET);
          on_pick = CFG_W'(ON_RESET);
        end
        default: begin
          warn_pick = ($urandom_range(1) == 0) ? CFG_W'($urandom_range(600)) : CFG_W'($urandom);
          on_pick = ($urandom_range(1) == 0) ? CFG_W'($urandom_range(60)) : CFG_W'($urandom);
        end
      endcase
      program_window(warn_pick, on_pick);
      calm = (p == 2);
      goal = words_sent + PHASE_WORDS;
      // first schedule of the run appends 60 to DEPTH + 6 entries, so it may fill the table past its depth
      if (p == 0) run_schedule(1'b1);
      while (words_sent < goal) begin
        if ($urandom_range(99) < 80) run_schedule(1'b0);
        else run_noise();
      end
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d words sent, %0d results checked over %0d window settings",
             words_sent, results_checked, PHASES + 1);
    $display("%0d beeps, %0d alarm rollovers, %0d appends dropped on a full table",
             beeps_seen, rollovers_seen, drops_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_weekly_alarm_scheduler: done, clean");
    end else begin
      $display("tb_weekly_alarm_scheduler: done, errors");
    end
    $finish;
  end

endmodule
